// File: rtl/srti_pkg.sv
// Shared types, codes and constants of the sorted record table insert unit.
package srti_pkg;

  // Default table depth
  localparam int DEPTH_DEF = 64;

  // Fixed field widths
  localparam int KEY_W    = 32;
  localparam int ID_W     = 32;
  localparam int MONTHS_W = 12;
  localparam int RD_IDX_W = 6;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  // Request types
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FILLED = 2'd3;

  // Input transaction
  typedef struct packed {
    logic                       req_type;
    logic signed [ID_W-1:0]     rec_id;
    logic        [KEY_W-1:0]    budget;
    logic        [MONTHS_W-1:0] months;
    logic        [RD_IDX_W-1:0] read_index;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic        [POS_W-1:0]    position;
    logic        [COUNT_W-1:0]  entry_count;
    logic signed [ID_W-1:0]     out_id;
    logic        [KEY_W-1:0]    out_budget;
    logic        [MONTHS_W-1:0] out_months;
  } out_t;

  // One stored record
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [ID_W-1:0]     id;
    logic [MONTHS_W-1:0] months;
  } rec_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic eval;    // compare stored record against the incoming transaction
    logic commit;  // apply the insert shift
  } ctl_t;

  // Per-cell compare results
  typedef struct packed {
    logic stay;      // valid and key >= new budget: record keeps its place
    logic take_new;  // first cell that does not stay: new record lands here
    logic dup;       // valid and id matches
    logic hit;       // valid and this cell is the read index
  } flag_t;

endpackage

// File: rtl/srti_cell.sv
// One table cell: holds a record, compares it and shifts it to its neighbor.
module srti_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  srti_pkg::ctl_t  ctl,
  input  srti_pkg::in_t   req,
  input  srti_pkg::rec_t  new_rec,
  input  srti_pkg::rec_t  prev_rec,
  input  logic            prev_valid,
  input  logic            prev_stay,
  output srti_pkg::rec_t  rec,
  output logic            valid,
  output srti_pkg::flag_t flags
);

  srti_pkg::rec_t rec_r;
  srti_pkg::rec_t rec_nxt;
  logic           valid_r;
  logic           valid_nxt;
  logic           stay_r;
  logic           dup_r;
  logic           hit_r;
  logic           take_new;
  logic           is_read_pos;

  assign take_new    = !stay_r && prev_stay;
  assign is_read_pos = (CELL_IDX < (1 << srti_pkg::RD_IDX_W)) &&
                       (req.read_index == srti_pkg::RD_IDX_W'(CELL_IDX));

  // Pick the next record: keep, take the new one, or take the upper neighbor's
  always_comb begin
    rec_nxt   = rec_r;
    valid_nxt = valid_r;
    if (ctl.commit && !stay_r) begin
      if (take_new) begin
        rec_nxt   = new_rec;
        valid_nxt = 1'b1;
      end else begin
        rec_nxt   = prev_rec;
        valid_nxt = prev_valid;
      end
    end
  end

  // Control: valid bit and compare flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stay_r  <= 1'b0;
      dup_r   <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.eval) begin
        stay_r <= valid_r && (rec_r.key >= req.budget);
        dup_r  <= valid_r && (rec_r.id == req.rec_id);
        hit_r  <= valid_r && is_read_pos;
      end
    end
  end

  // Payload: record storage
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec            = rec_r;
  assign valid          = valid_r;
  assign flags.stay     = stay_r;
  assign flags.take_new = take_new;
  assign flags.dup      = dup_r;
  assign flags.hit      = hit_r;

endmodule

// File: rtl/sorted_record_table_insert_unit.sv
// Top level of the sorted record table insert unit: cell chain and result logic.
//
//  channel | ports                     | direction | handshake
//  --------+---------------------------+-----------+--------------------------------
//  input   | start, busy, in_item      | in        | accepted when start && !busy
//  result  | out_valid, out_result     | out       | one-cycle strobe, no back pressure
//
// A transaction is handled in two registered steps: on accept each cell compares
// its record against the transaction and registers the flags; then the flags
// are reduced, the shift is committed and the result is registered. busy is
// high for the one cycle in between, so no new transaction is accepted while
// one is in flight. The result strobe lasts one cycle and the receiver cannot
// stall it. Reset empties the table.
module sorted_record_table_insert_unit #(
  parameter int DEPTH = srti_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  srti_pkg::in_t   in_item,
  output logic            out_valid,
  output srti_pkg::out_t  out_result
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > srti_pkg::RD_IDX_W) ? CNT_W : srti_pkg::RD_IDX_W;

  logic            busy_r;
  logic            busy_nxt;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  srti_pkg::in_t   req_r;
  srti_pkg::out_t  out_r;
  srti_pkg::out_t  out_nxt;
  logic            out_valid_r;

  srti_pkg::ctl_t  ctl;
  srti_pkg::rec_t  new_rec;
  srti_pkg::rec_t  rec_a   [DEPTH];
  logic            valid_a [DEPTH];
  srti_pkg::flag_t flags_a [DEPTH];
  logic [DEPTH-1:0] take_new_v;

  logic            accept;
  logic            dup_any;
  logic            full;
  logic            ins_ok;
  logic            read_ok;
  srti_pkg::rec_t  read_rec;
  logic [IDX_W-1:0] ins_pos;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  assign new_rec.key    = req_r.budget;
  assign new_rec.id     = req_r.rec_id;
  assign new_rec.months = req_r.months;

  assign full    = (fill_r == CNT_W'(DEPTH));
  assign ins_ok  = busy_r && (req_r.req_type == srti_pkg::REQ_INSERT) && !dup_any && !full;
  assign read_ok = CMP_W'(req_r.read_index) < CMP_W'(fill_r);

  assign ctl.eval   = accept;
  assign ctl.commit = ins_ok;

  // Build the cell chain; cell 0 sees a staying, empty neighbor above it
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      srti_cell #(.CELL_IDX(gi)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .req        (in_item),
        .new_rec    (new_rec),
        .prev_rec   (new_rec),
        .prev_valid (1'b0),
        .prev_stay  (1'b1),
        .rec        (rec_a[gi]),
        .valid      (valid_a[gi]),
        .flags      (flags_a[gi])
      );
    end else begin : g_body
      srti_cell #(.CELL_IDX(gi)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .req        (in_item),
        .new_rec    (new_rec),
        .prev_rec   (rec_a[gi-1]),
        .prev_valid (valid_a[gi-1]),
        .prev_stay  (flags_a[gi-1].stay),
        .rec        (rec_a[gi]),
        .valid      (valid_a[gi]),
        .flags      (flags_a[gi])
      );
    end
    assign take_new_v[gi] = flags_a[gi].take_new;
  end

  // Reduce cell flags: duplicate, read data and landing position
  always_comb begin
    dup_any  = 1'b0;
    read_rec = '0;
    ins_pos  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      dup_any  = dup_any | flags_a[i].dup;
      read_rec = read_rec | (flags_a[i].hit ? rec_a[i] : '0);
      ins_pos  = ins_pos | (flags_a[i].take_new ? IDX_W'(i) : '0);
    end
  end

  // Form the result and the next fill count
  always_comb begin
    out_nxt  = '0;
    fill_nxt = fill_r;
    if (req_r.req_type == srti_pkg::REQ_READ) begin
      out_nxt.position = req_r.read_index;
      if (read_ok) begin
        out_nxt.status     = srti_pkg::ST_OK;
        out_nxt.out_id     = read_rec.id;
        out_nxt.out_budget = read_rec.key;
        out_nxt.out_months = read_rec.months;
      end else begin
        out_nxt.status = srti_pkg::ST_NOT_FILLED;
      end
    end else if (dup_any) begin
      out_nxt.status = srti_pkg::ST_DUPLICATE;
    end else if (full) begin
      out_nxt.status = srti_pkg::ST_FULL;
    end else begin
      out_nxt.status   = srti_pkg::ST_OK;
      out_nxt.position = srti_pkg::POS_W'(ins_pos);
      fill_nxt         = fill_r + CNT_W'(1);
    end
    out_nxt.entry_count = srti_pkg::COUNT_W'(fill_nxt);
  end

  assign busy_nxt = accept ? 1'b1 : 1'b0;

  // Control: busy flag, fill count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= busy_r;
      if (busy_r) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // Payload: hold the transaction and the result
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
    if (busy_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // Checks
  a_strobe_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy_r))
    else $error("result strobe without a transaction in flight");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds table depth");

  a_one_landing: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot0(take_new_v))
    else $error("more than one landing cell");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("accepted insert did not grow the table");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("transaction overlap");

endmodule
